// ===== src/cde_pkg.sv =====
// Package for the circular deque engine.
// Holds operation codes, status codes, controller command codes and the
// command/status structs shared by controller and datapath.
package cde_pkg;

    localparam int WORD_W  = 32;
    localparam int FUNC_W  = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Operation codes carried by func
    localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 4'd2;
    localparam logic [FUNC_W-1:0] OP_POP_BACK   = 4'd3;
    localparam logic [FUNC_W-1:0] OP_PEEK_FRONT = 4'd4;
    localparam logic [FUNC_W-1:0] OP_PEEK_BACK  = 4'd5;
    localparam logic [FUNC_W-1:0] OP_CLEAR      = 4'd6;
    localparam logic [FUNC_W-1:0] OP_REVERSE    = 4'd7;
    localparam logic [FUNC_W-1:0] OP_SORT       = 4'd8;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Datapath command codes
    localparam int CMD_W = 5;
    localparam logic [CMD_W-1:0] CMD_NONE      = 5'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD      = 5'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH      = 5'd2;
    localparam logic [CMD_W-1:0] CMD_READ      = 5'd3;
    localparam logic [CMD_W-1:0] CMD_TAKE      = 5'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 5'd5;
    localparam logic [CMD_W-1:0] CMD_WALK_INIT = 5'd6;
    localparam logic [CMD_W-1:0] CMD_GRD       = 5'd7;
    localparam logic [CMD_W-1:0] CMD_GWR       = 5'd8;
    localparam logic [CMD_W-1:0] CMD_PASS_INIT = 5'd9;
    localparam logic [CMD_W-1:0] CMD_SRD0      = 5'd10;
    localparam logic [CMD_W-1:0] CMD_SH0       = 5'd11;
    localparam logic [CMD_W-1:0] CMD_SRD       = 5'd12;
    localparam logic [CMD_W-1:0] CMD_SCMP      = 5'd13;
    localparam logic [CMD_W-1:0] CMD_SEND      = 5'd14;
    localparam logic [CMD_W-1:0] CMD_PRD       = 5'd15;
    localparam logic [CMD_W-1:0] CMD_PWR       = 5'd16;
    localparam logic [CMD_W-1:0] CMD_FINISH    = 5'd17;
    localparam logic [CMD_W-1:0] CMD_EMPTY     = 5'd18;
    localparam logic [CMD_W-1:0] CMD_FULL      = 5'd19;

    typedef struct packed {
        logic [CMD_W-1:0] code;
    } cde_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] op;
        logic              empty;
        logic              full;
        logic              few;        // fewer than two entries
        logic              walk_last;  // walk index at last entry
        logic              pass_last;  // walk index at pass limit
        logic              lim_one;    // final sort pass
    } cde_stat_t;

endpackage

// ===== src/cde_dp.sv =====
// Datapath of the circular deque engine: entry store, scratch store,
// indices, count, walk counters and result register. Uses cde_pkg.
module cde_dp #(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cde_pkg::cde_cmd_t            cmd,
    input  logic [cde_pkg::FUNC_W-1:0]   func,
    input  logic signed [cde_pkg::WORD_W-1:0] push_value,
    output cde_pkg::cde_stat_t           stat,
    output logic signed [cde_pkg::WORD_W-1:0] out_value,
    output logic [cde_pkg::STAT_W-1:0]   status,
    output logic [cde_pkg::COUNT_W-1:0]  entry_count,
    output logic                         is_empty
);
    import cde_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [WORD_W-1:0] store_mem [DEPTH];
    logic signed [WORD_W-1:0] scr_mem   [DEPTH];

    logic [IW-1:0]            head_reg, head_next;
    logic [IW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            k_reg, k_next;
    logic [CW-1:0]            lim_reg, lim_next;
    logic signed [WORD_W-1:0] hold_reg, hold_next;
    logic [FUNC_W-1:0]        op_reg, op_next;
    logic signed [WORD_W-1:0] val_reg, val_next;
    logic signed [WORD_W-1:0] res_reg, res_next;
    logic [STAT_W-1:0]        st_reg, st_next;

    logic signed [WORD_W-1:0] out_value_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic [CW-1:0]            out_count_reg;

    logic                     st_we;
    logic [IW-1:0]            st_wa, st_ra;
    logic signed [WORD_W-1:0] st_wd, st_rq;
    logic                     sc_we;
    logic [IW-1:0]            sc_wa, sc_ra;
    logic signed [WORD_W-1:0] sc_wd, sc_rq;

    logic [CW-1:0]            last_k;
    logic [CW-1:0]            rev_k;
    logic                     front;

    // Add two indices modulo DEPTH
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(DEPTH))
            s = s - (CW+1)'(DEPTH);
        return s[IW-1:0];
    endfunction

    assign last_k = count_reg - CW'(1);
    assign rev_k  = last_k - k_reg;
    assign front  = (op_reg == OP_POP_FRONT) || (op_reg == OP_PEEK_FRONT);

    // Status to controller
    assign stat.op        = op_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg >= CW'(DEPTH));
    assign stat.few       = (count_reg < CW'(2));
    assign stat.walk_last = (k_reg == last_k);
    assign stat.pass_last = (k_reg == lim_reg);
    assign stat.lim_one   = (lim_reg == CW'(1));

    // Entry store: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_wa] <= st_wd;
        st_rq <= store_mem[st_ra];
    end

    // Scratch store used by reverse and sort
    always_ff @(posedge clk)
    begin
        if (sc_we)
            scr_mem[sc_wa] <= sc_wd;
        sc_rq <= scr_mem[sc_ra];
    end

    // Decode command into next state and memory accesses
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        count_next = count_reg;
        k_next = k_reg;
        lim_next = lim_reg;
        hold_next = hold_reg;
        op_next = op_reg;
        val_next = val_reg;
        res_next = res_reg;
        st_next = st_reg;
        st_we = 1'b0;
        st_wa = head_reg;
        st_wd = val_reg;
        st_ra = wrap_add(head_reg, k_reg);
        sc_we = 1'b0;
        sc_wa = k_reg[IW-1:0];
        sc_wd = st_rq;
        sc_ra = k_reg[IW-1:0];
        case (cmd.code)
            CMD_LOAD:
            begin
                op_next = func;
                val_next = push_value;
                res_next = '0;
                st_next = ST_OK;
            end
            CMD_FULL:
                st_next = ST_FULL;
            CMD_EMPTY:
                st_next = ST_EMPTY;
            CMD_PUSH:
            begin
                st_we = 1'b1;
                if (count_reg == '0)
                begin
                    head_next = '0;
                    tail_next = '0;
                    st_wa = '0;
                end
                else if (op_reg == OP_PUSH_FRONT)
                begin
                    head_next = wrap_add(head_reg, CW'(DEPTH - 1));
                    st_wa = head_next;
                end
                else
                begin
                    tail_next = wrap_add(tail_reg, CW'(1));
                    st_wa = tail_next;
                end
                count_next = count_reg + CW'(1);
            end
            CMD_READ:
                st_ra = front ? head_reg : tail_reg;
            CMD_TAKE:
            begin
                res_next = st_rq;
                if ((op_reg == OP_POP_FRONT) || (op_reg == OP_POP_BACK))
                begin
                    if (count_reg > CW'(1))
                    begin
                        if (front)
                            head_next = wrap_add(head_reg, CW'(1));
                        else
                            tail_next = wrap_add(tail_reg, CW'(DEPTH - 1));
                    end
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_CLEAR:
            begin
                head_next = '0;
                tail_next = '0;
                count_next = '0;
            end
            CMD_WALK_INIT:
                k_next = '0;
            CMD_GRD:
                st_ra = wrap_add(head_reg, k_reg);
            CMD_GWR:
            begin
                sc_we = 1'b1;
                sc_wa = k_reg[IW-1:0];
                sc_wd = st_rq;
                k_next = k_reg + CW'(1);
            end
            CMD_PASS_INIT:
            begin
                lim_next = last_k;
                k_next = '0;
            end
            CMD_SRD0:
                sc_ra = '0;
            CMD_SH0:
            begin
                hold_next = sc_rq;
                k_next = CW'(1);
            end
            CMD_SRD:
                sc_ra = k_reg[IW-1:0];
            CMD_SCMP:
            begin
                // Carry the larger word forward, drop the smaller one behind
                sc_we = 1'b1;
                sc_wa = k_reg[IW-1:0] - IW'(1);
                if (hold_reg > sc_rq)
                    sc_wd = sc_rq;
                else
                begin
                    sc_wd = hold_reg;
                    hold_next = sc_rq;
                end
                k_next = k_reg + CW'(1);
            end
            CMD_SEND:
            begin
                sc_we = 1'b1;
                sc_wa = lim_reg[IW-1:0];
                sc_wd = hold_reg;
                lim_next = lim_reg - CW'(1);
                k_next = '0;
            end
            CMD_PRD:
                sc_ra = (op_reg == OP_REVERSE) ? rev_k[IW-1:0] : k_reg[IW-1:0];
            CMD_PWR:
            begin
                st_we = 1'b1;
                st_wd = sc_rq;
                st_wa = (op_reg == OP_SORT) ? k_reg[IW-1:0] : wrap_add(head_reg, k_reg);
                k_next = k_reg + CW'(1);
                if ((op_reg == OP_SORT) && (k_reg == last_k))
                begin
                    head_next = '0;
                    tail_next = last_k[IW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            count_reg <= '0;
            k_reg <= '0;
            lim_reg <= '0;
            op_reg <= OP_CLEAR;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            count_reg <= count_next;
            k_reg <= k_next;
            lim_reg <= lim_next;
            op_reg <= op_next;
        end
    end

    // Payload registers and output register
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        val_reg <= val_next;
        res_reg <= res_next;
        st_reg <= st_next;
        if (cmd.code == CMD_FINISH)
        begin
            out_value_reg <= res_reg;
            out_status_reg <= st_reg;
            out_count_reg <= count_reg;
        end
    end

    assign out_value   = out_value_reg;
    assign status      = out_status_reg;
    assign entry_count = COUNT_W'(out_count_reg);
    assign is_empty    = (out_count_reg == '0);

endmodule

// ===== src/cde_ctrl.sv =====
// Controller state machine of the circular deque engine.
// Sequences datapath commands per request. Uses cde_pkg.
module cde_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               out_stall,
    input  cde_pkg::cde_stat_t stat,
    output logic               in_stall,
    output logic               out_valid,
    output cde_pkg::cde_cmd_t  cmd
);
    import cde_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_RDATA = 4'd2;
    localparam logic [3:0] S_GRD   = 4'd3;
    localparam logic [3:0] S_GWR   = 4'd4;
    localparam logic [3:0] S_PINIT = 4'd5;
    localparam logic [3:0] S_SRD0  = 4'd6;
    localparam logic [3:0] S_SH0   = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SCMP  = 4'd9;
    localparam logic [3:0] S_SEND  = 4'd10;
    localparam logic [3:0] S_SINIT = 4'd11;
    localparam logic [3:0] S_PRD   = 4'd12;
    localparam logic [3:0] S_PWR   = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       finish;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    // Load the output register once any earlier result has left
    assign finish    = (state_reg == S_DONE) && !(out_valid_reg && out_stall);

    // Next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd.code = CMD_NONE;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    cmd.code = CMD_LOAD;
                    state_next = S_EXEC;
                end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (stat.op)
                    OP_PUSH_FRONT, OP_PUSH_BACK:
                        cmd.code = stat.full ? CMD_FULL : CMD_PUSH;
                    OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK:
                        if (stat.empty)
                            cmd.code = CMD_EMPTY;
                        else
                        begin
                            cmd.code = CMD_READ;
                            state_next = S_RDATA;
                        end
                    OP_CLEAR:
                        cmd.code = CMD_CLEAR;
                    OP_REVERSE, OP_SORT:
                        if (!stat.few)
                        begin
                            cmd.code = CMD_WALK_INIT;
                            state_next = S_GRD;
                        end
                    default:
                        cmd.code = CMD_NONE;
                endcase
            end
            S_RDATA:
            begin
                cmd.code = CMD_TAKE;
                state_next = S_DONE;
            end
            S_GRD:
            begin
                cmd.code = CMD_GRD;
                state_next = S_GWR;
            end
            S_GWR:
            begin
                cmd.code = CMD_GWR;
                if (!stat.walk_last)
                    state_next = S_GRD;
                else if (stat.op == OP_SORT)
                    state_next = S_PINIT;
                else
                    state_next = S_SINIT;
            end
            S_PINIT:
            begin
                cmd.code = CMD_PASS_INIT;
                state_next = S_SRD0;
            end
            S_SRD0:
            begin
                cmd.code = CMD_SRD0;
                state_next = S_SH0;
            end
            S_SH0:
            begin
                cmd.code = CMD_SH0;
                state_next = S_SRD;
            end
            S_SRD:
            begin
                cmd.code = CMD_SRD;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                cmd.code = CMD_SCMP;
                state_next = stat.pass_last ? S_SEND : S_SRD;
            end
            S_SEND:
            begin
                cmd.code = CMD_SEND;
                state_next = stat.lim_one ? S_SINIT : S_SRD0;
            end
            S_SINIT:
            begin
                cmd.code = CMD_WALK_INIT;
                state_next = S_PRD;
            end
            S_PRD:
            begin
                cmd.code = CMD_PRD;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                cmd.code = CMD_PWR;
                state_next = stat.walk_last ? S_DONE : S_PRD;
            end
            S_DONE:
                // Hold here while the previous result waits
                if (finish)
                begin
                    cmd.code = CMD_FINISH;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold the result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (finish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/circular_deque_engine.sv =====
// Circular deque engine: one request at a time. Push, clear and empty or full
// cases finish from the execute state; pop and peek add a registered store read.
// Reverse and sort copy the entries through the scratch store and back.
// A new request is taken in the cycle after the result is loaded; a result
// still waiting holds the next one in its last state.
// Reset empties the deque at once.
module circular_deque_engine #(
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cde_pkg::FUNC_W-1:0]        func,
    input  logic signed [cde_pkg::WORD_W-1:0] push_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cde_pkg::WORD_W-1:0] out_value,
    output logic [cde_pkg::STAT_W-1:0]        status,
    output logic [cde_pkg::COUNT_W-1:0]       entry_count,
    output logic                              is_empty
);
    import cde_pkg::*;

    cde_cmd_t  cmd;
    cde_stat_t stat;

    // Sequence requests
    cde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Hold the store and indices
    cde_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .push_value  (push_value),
        .stat        (stat),
        .out_value   (out_value),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

endmodule

// ===== sim/deque_checker.sv =====
// Checker for the circular deque engine: watches both channels, keeps its own
// deque model and compares every result field by field.
// Depends on cde_pkg for operation and status codes.
module deque_checker #(
    parameter int DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [cde_pkg::FUNC_W-1:0]        func,
    input  logic signed [cde_pkg::WORD_W-1:0] push_value,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [cde_pkg::WORD_W-1:0] out_value,
    input  logic [cde_pkg::STAT_W-1:0]        status,
    input  logic [cde_pkg::COUNT_W-1:0]       entry_count,
    input  logic                              is_empty,
    output int                                fail_count,
    output int                                pending
);
    import cde_pkg::*;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
        logic [STAT_W-1:0]        stat;
        logic [COUNT_W-1:0]       count;
        logic                     empty;
    } deque_result_t;

    // Model deque kept front to back; ordering in the store does not show outside
    logic signed [WORD_W-1:0] model_words[$];
    deque_result_t            expected_results[$];

    // Work out the result of one request and update the model deque
    function automatic deque_result_t apply_request(logic [FUNC_W-1:0] op,
                                                    logic signed [WORD_W-1:0] val);
        deque_result_t r;
        logic signed [WORD_W-1:0] tmp;
        r = '0;
        r.stat = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (model_words.size() >= DEPTH)
                    r.stat = ST_FULL;
                else if (op == OP_PUSH_FRONT)
                    model_words.insert(0, val);
                else
                    model_words.insert(model_words.size(), val);
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK:
            begin
                if (model_words.size() == 0)
                    r.stat = ST_EMPTY;
                else if (op == OP_POP_FRONT)
                begin
                    r.word = model_words[0];
                    model_words.delete(0);
                end
                else if (op == OP_POP_BACK)
                begin
                    r.word = model_words[$];
                    model_words.delete(model_words.size() - 1);
                end
                else if (op == OP_PEEK_FRONT)
                    r.word = model_words[0];
                else
                    r.word = model_words[$];
            end
            OP_CLEAR:
                model_words.delete();
            OP_REVERSE:
                model_words.reverse();
            OP_SORT:
            begin
                // insertion sort, signed ascending
                for (int k = 1; k < model_words.size(); k++)
                begin
                    int m;
                    tmp = model_words[k];
                    m = k;
                    while (m > 0 && model_words[m-1] > tmp)
                    begin
                        model_words[m] = model_words[m-1];
                        m--;
                    end
                    model_words[m] = tmp;
                end
            end
            default:
                ;
        endcase
        r.count = COUNT_W'(model_words.size());
        r.empty = (model_words.size() == 0);
        return r;
    endfunction

    // Predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        deque_result_t exp_r;
        deque_result_t new_r;
        if (!rst_n)
        begin
            model_words.delete();
            expected_results.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                new_r = apply_request(func, push_value);
                expected_results.insert(expected_results.size(), new_r);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    if (out_value !== exp_r.word)
                        $error("out_value exp %0d got %0d", exp_r.word, out_value);
                    if (status !== exp_r.stat)
                        $error("status exp %0d got %0d", exp_r.stat, status);
                    if (entry_count !== exp_r.count)
                        $error("entry_count exp %0d got %0d", exp_r.count, entry_count);
                    if (is_empty !== exp_r.empty)
                        $error("is_empty exp %0d got %0d", exp_r.empty, is_empty);
                    if (out_value !== exp_r.word || status !== exp_r.stat ||
                        entry_count !== exp_r.count || is_empty !== exp_r.empty)
                        fail_count <= fail_count + 1;
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ===== sim/tb_circular_deque_engine.sv =====
// Testbench top for the circular deque engine: drives requests and result
// stalls, and gives the verdict. Depends on cde_pkg and deque_checker.
module tb_circular_deque_engine;
    import cde_pkg::*;

    localparam int DEPTH       = 64;
    localparam int RANDOM_REQS = 1050;
    localparam int CYCLE_LIMIT = 20000000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] push_value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [WORD_W-1:0] out_value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    int                       fail_count;
    int                       pending;
    int                       cycle_count = 0;
    bit                       hold_off;
    bit                       sort_heavy;

    circular_deque_engine #(.DEPTH(DEPTH)) i_dut (.*);

    deque_checker #(.DEPTH(DEPTH)) i_checker (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Gap length: mostly short, now and then long
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // Result stalls at random; one long hold-off when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat (gap_len()) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Offer one request and hold it until taken
    task automatic send_request(input logic [FUNC_W-1:0] op,
                                input logic signed [WORD_W-1:0] val);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func       <= op;
        push_value <= val;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random word with extremes weighted in
    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(0, 20))) - 10;
            default: return $urandom();
        endcase
    endfunction

    // Pick an operation; sorts kept rare as they are slow on a full deque
    function automatic logic [FUNC_W-1:0] rand_op(bit filling);
        int p;
        p = $urandom_range(0, 99);
        if (p < 2)
            return FUNC_W'($urandom_range(9, 15));
        if (p < 4)
            return OP_CLEAR;
        if (p < 8)
            return OP_REVERSE;
        if (p < (sort_heavy ? 16 : 9))
            return OP_SORT;
        if (p < (filling ? 70 : 35))
            return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        return FUNC_W'($urandom_range(2, 5));
    endfunction

    // Stimulus
    initial
    begin
        bit filling;
        hold_off    = 1'b0;
        sort_heavy  = 1'b0;
        in_valid    = 1'b0;
        func        = OP_CLEAR;
        push_value  = '0;
        rst_n       = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty cases, extremes, every operation
        send_request(OP_POP_FRONT, 0);
        send_request(OP_POP_BACK, 0);
        send_request(OP_PEEK_FRONT, 0);
        send_request(OP_PEEK_BACK, 0);
        send_request(OP_REVERSE, 0);
        send_request(OP_SORT, 0);
        send_request(OP_PUSH_BACK, 32'sh7fff_ffff);
        send_request(OP_SORT, 0);
        send_request(OP_PUSH_FRONT, 32'sh8000_0000);
        send_request(OP_PUSH_BACK, -1);
        send_request(OP_PUSH_FRONT, 0);
        send_request(OP_PEEK_FRONT, 0);
        send_request(OP_PEEK_BACK, 0);
        send_request(OP_REVERSE, 0);
        send_request(OP_SORT, 0);
        send_request(OP_POP_FRONT, 0);
        send_request(OP_POP_BACK, 0);
        send_request(4'd15, 32'sh5555_aaaa);
        send_request(4'd9, 0);
        send_request(OP_CLEAR, 0);
        send_request(OP_POP_BACK, 0);

        // Fill to full and push past it, then sort and reverse
        for (int k = 0; k < DEPTH + 2; k++)
            send_request((k % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word());
        send_request(OP_SORT, 0);
        send_request(OP_REVERSE, 0);

        // Long result hold-off while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 12; k++)
                send_request(FUNC_W'($urandom_range(2, 5)), 0);
        join

        // Random part: alternate filling and draining phases
        filling = 1'b1;
        for (int k = 0; k < RANDOM_REQS; k++)
        begin
            if ($urandom_range(0, 59) == 0)
                filling = !filling;
            sort_heavy = (k % 400) < 40;
            send_request(rand_op(filling), rand_word());
        end
        in_valid <= 1'b0;

        // Drain
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
